>>> sv/scd_pkg.sv
// Shared types, widths and reset constants of the signed command to dual PWM mapper.
package scd_pkg;

    localparam int CMD_W      = 16;
    localparam int CMAX_W     = 15;
    localparam int DUTY_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int IDX_W      = 3;
    localparam int PROD_W     = CMAX_W + DUTY_W;
    localparam int NUM_W      = PROD_W + GAIN_W;
    localparam int SUM_W      = NUM_W + 1;
    localparam int GAIN_FRAC  = 12;
    localparam int COUNT_FRAC = 8;
    localparam int ROUND_SH   = GAIN_FRAC + COUNT_FRAC;
    localparam int HALF_SH    = ROUND_SH - 1;
    localparam int Q_W        = 17;
    localparam int REM_W      = CMAX_W;
    localparam int DIV_CELLS  = Q_W;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic [IDX_W-1:0] {
        REG_CMD_CEILING    = 3'd0,
        REG_CMD_FLOOR      = 3'd1,
        REG_ZERO_BAND      = 3'd2,
        REG_DUTY_CEILING   = 3'd3,
        REG_LEFT_DEADBAND  = 3'd4,
        REG_RIGHT_DEADBAND = 3'd5,
        REG_LEFT_GAIN      = 3'd6,
        REG_RIGHT_GAIN     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CMAX_W-1:0]        cmd_ceiling;
        logic signed [CMD_W-1:0]  cmd_floor;
        logic [CMAX_W-1:0]        zero_band;
        logic [DUTY_W-1:0]        duty_ceiling;
        logic [DUTY_W-1:0]        left_deadband;
        logic [DUTY_W-1:0]        right_deadband;
        logic [GAIN_W-1:0]        left_gain;
        logic [GAIN_W-1:0]        right_gain;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cmd_ceiling:    15'd25600,
        cmd_floor:      -16'sd25600,
        zero_band:      15'd128,
        duty_ceiling:   24'd25344,
        left_deadband:  24'd3328,
        right_deadband: 24'd3328,
        left_gain:      16'd4096,
        right_gain:     16'd4096
    };

    typedef struct packed {
        logic             sat;
        logic [Q_W-1:0]   sat_val;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   bits;
    } t_lane;

    typedef struct packed {
        t_dir  dir;
        logic  zero;
        t_lane lane_l;
        t_lane lane_r;
    } t_div_data;

endpackage

>>> sv/scd_cmd_if.sv
// Command channel carrying one signed drive command per transfer.
interface scd_cmd_if;
    logic                                valid;
    logic                                ready;
    logic signed [scd_pkg::CMD_W-1:0]    drive_command;

    modport source (output valid, output drive_command, input ready);
    modport sink (input valid, input drive_command, output ready);
endinterface

>>> sv/scd_res_if.sv
// Result channel carrying the directions and compare values of both motors.
interface scd_res_if #(
    parameter int COMPARE_WIDTH = 16
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               left_dir;
    logic [1:0]               right_dir;
    logic [COMPARE_WIDTH-1:0] left_duty;
    logic [COMPARE_WIDTH-1:0] right_duty;

    modport source (output valid, output left_dir, output right_dir, output left_duty,
                    output right_duty, input ready);
    modport sink (input valid, input left_dir, input right_dir, input left_duty,
                  input right_duty, output ready);
endinterface

>>> sv/scd_cfg_if.sv
// Configuration write channel carrying a register index and write data.
interface scd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [scd_pkg::IDX_W-1:0]      index;
    logic [scd_pkg::DUTY_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/scd_cfg_regs.sv
// Configuration register file with reset defaults.
module scd_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scd_cfg_if.sink       i_cfg,
    output scd_pkg::t_cfg o_cfg
);

    scd_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= scd_pkg::CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (scd_pkg::t_reg_idx'(i_cfg.index))
                scd_pkg::REG_CMD_CEILING: begin
                    r_cfg.cmd_ceiling <= i_cfg.data[scd_pkg::CMAX_W-1:0];
                end
                scd_pkg::REG_CMD_FLOOR: begin
                    r_cfg.cmd_floor <= $signed(i_cfg.data[scd_pkg::CMD_W-1:0]);
                end
                scd_pkg::REG_ZERO_BAND: begin
                    r_cfg.zero_band <= i_cfg.data[scd_pkg::CMAX_W-1:0];
                end
                scd_pkg::REG_DUTY_CEILING: begin
                    r_cfg.duty_ceiling <= i_cfg.data;
                end
                scd_pkg::REG_LEFT_DEADBAND: begin
                    r_cfg.left_deadband <= i_cfg.data;
                end
                scd_pkg::REG_RIGHT_DEADBAND: begin
                    r_cfg.right_deadband <= i_cfg.data;
                end
                scd_pkg::REG_LEFT_GAIN: begin
                    r_cfg.left_gain <= i_cfg.data[scd_pkg::GAIN_W-1:0];
                end
                scd_pkg::REG_RIGHT_GAIN: begin
                    r_cfg.right_gain <= i_cfg.data[scd_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> sv/scd_premap.sv
// Clamp, direction and scaled duty numerator pipeline ahead of the divider.
module scd_premap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scd_pkg::t_cfg      i_cfg,
    scd_cmd_if.sink            i_cmd,
    output logic               o_valid,
    output scd_pkg::t_div_data o_data,
    input  logic               i_ready
);

    localparam int CW  = scd_pkg::CMAX_W;
    localparam int DW  = scd_pkg::DUTY_W;
    localparam int PW  = scd_pkg::PROD_W;
    localparam int NW  = scd_pkg::NUM_W;
    localparam int SW  = scd_pkg::SUM_W;
    localparam int QW  = scd_pkg::Q_W;
    localparam int RW  = scd_pkg::REM_W;
    localparam int XW  = scd_pkg::CMD_W + 1;
    localparam int AW  = DW + 1;

    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    logic signed [XW-1:0] cmd_x, max_x, min_x, zb_x, clamp_x, mag_x;
    scd_pkg::t_dir        n_dir;
    logic [CW-1:0]        n_mag;
    logic                 n_zero;

    scd_pkg::t_dir r_dir0, r_dir1, r_dir2, r_dir3;
    logic          r_zero0, r_zero1, r_zero2, r_zero3;
    logic [CW-1:0] r_mag0;

    logic [DW-1:0] span_l, span_r;
    logic [PW-1:0] r_pdb_l, r_pdb_r, r_pms_l, r_pms_r, r_pd1;
    logic [PW-1:0] r_t_l, r_t_r, r_pd2;
    logic [NW-1:0] r_num_l, r_num_r;
    logic [PW-1:0] r_pd3;

    logic [SW-1:0] sum_l, sum_r;
    logic [NW-1:0] lim_num;
    logic [QW-1:0] sat_val;
    scd_pkg::t_div_data n_data, r_data4;

    assign rdy4        = !r_v4 || i_ready;
    assign rdy3        = !r_v3 || rdy4;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign rdy0        = !r_v0 || rdy1;
    assign i_cmd.ready = rdy0;
    assign o_valid     = r_v4;
    assign o_data      = r_data4;

    always_comb begin
        cmd_x = $signed({i_cmd.drive_command[scd_pkg::CMD_W-1], i_cmd.drive_command});
        max_x = $signed({2'b00, i_cfg.cmd_ceiling});
        min_x = $signed({i_cfg.cmd_floor[scd_pkg::CMD_W-1], i_cfg.cmd_floor});
        zb_x  = $signed({2'b00, i_cfg.zero_band});
        if (cmd_x > max_x) begin
            clamp_x = max_x;
        end else if (cmd_x < min_x) begin
            clamp_x = min_x;
        end else begin
            clamp_x = cmd_x;
        end
        if (clamp_x > zb_x) begin
            n_dir = scd_pkg::DIR_FWD;
            mag_x = clamp_x;
        end else if (clamp_x < -zb_x) begin
            n_dir = scd_pkg::DIR_REV;
            mag_x = -clamp_x;
        end else begin
            n_dir = scd_pkg::DIR_STOP;
            mag_x = '0;
        end
        n_mag  = (mag_x > max_x) ? i_cfg.cmd_ceiling : mag_x[CW-1:0];
        n_zero = (n_dir == scd_pkg::DIR_STOP) || (i_cfg.cmd_ceiling == '0)
                 || (i_cfg.duty_ceiling == '0);
    end

    assign span_l = (i_cfg.duty_ceiling > i_cfg.left_deadband)
                    ? i_cfg.duty_ceiling - i_cfg.left_deadband : '0;
    assign span_r = (i_cfg.duty_ceiling > i_cfg.right_deadband)
                    ? i_cfg.duty_ceiling - i_cfg.right_deadband : '0;

    always_comb begin
        lim_num = NW'(r_pd3) << scd_pkg::GAIN_FRAC;
        sum_l   = SW'(r_num_l) + (SW'(i_cfg.cmd_ceiling) << scd_pkg::HALF_SH);
        sum_r   = SW'(r_num_r) + (SW'(i_cfg.cmd_ceiling) << scd_pkg::HALF_SH);
        sat_val = QW'((AW'(i_cfg.duty_ceiling) + AW'(128)) >> scd_pkg::COUNT_FRAC);

        n_data.dir            = r_dir3;
        n_data.zero           = r_zero3;
        n_data.lane_l.sat     = r_num_l >= lim_num;
        n_data.lane_l.sat_val = sat_val;
        n_data.lane_l.rem     = sum_l[scd_pkg::ROUND_SH+QW+RW-1:scd_pkg::ROUND_SH+QW];
        n_data.lane_l.bits    = sum_l[scd_pkg::ROUND_SH+QW-1:scd_pkg::ROUND_SH];
        n_data.lane_r.sat     = r_num_r >= lim_num;
        n_data.lane_r.sat_val = sat_val;
        n_data.lane_r.rem     = sum_r[scd_pkg::ROUND_SH+QW+RW-1:scd_pkg::ROUND_SH+QW];
        n_data.lane_r.bits    = sum_r[scd_pkg::ROUND_SH+QW-1:scd_pkg::ROUND_SH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_cmd.valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_dir0  <= n_dir;
            r_zero0 <= n_zero;
            r_mag0  <= n_mag;
        end
        if (rdy1) begin
            r_dir1  <= r_dir0;
            r_zero1 <= r_zero0;
            r_pdb_l <= PW'(i_cfg.left_deadband) * PW'(i_cfg.cmd_ceiling);
            r_pdb_r <= PW'(i_cfg.right_deadband) * PW'(i_cfg.cmd_ceiling);
            r_pms_l <= PW'(r_mag0) * PW'(span_l);
            r_pms_r <= PW'(r_mag0) * PW'(span_r);
            r_pd1   <= PW'(i_cfg.duty_ceiling) * PW'(i_cfg.cmd_ceiling);
        end
        if (rdy2) begin
            r_dir2  <= r_dir1;
            r_zero2 <= r_zero1;
            r_t_l   <= r_pdb_l + r_pms_l;
            r_t_r   <= r_pdb_r + r_pms_r;
            r_pd2   <= r_pd1;
        end
        if (rdy3) begin
            r_dir3  <= r_dir2;
            r_zero3 <= r_zero2;
            r_num_l <= NW'(r_t_l) * NW'(i_cfg.left_gain);
            r_num_r <= NW'(r_t_r) * NW'(i_cfg.right_gain);
            r_pd3   <= r_pd2;
        end
        if (rdy4) begin
            r_data4 <= n_data;
        end
    end

endmodule

>>> sv/scd_div_cell.sv
// One restoring divider cell that settles one quotient bit for each motor.
module scd_div_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [scd_pkg::CMAX_W-1:0] i_divisor,
    input  logic                       i_valid,
    input  scd_pkg::t_div_data         i_data,
    output logic                       o_ready,
    output logic                       o_valid,
    output scd_pkg::t_div_data         o_data,
    input  logic                       i_ready
);

    localparam int RW = scd_pkg::REM_W;
    localparam int QW = scd_pkg::Q_W;

    logic               r_valid;
    scd_pkg::t_div_data r_data;
    scd_pkg::t_div_data n_data;

    function automatic scd_pkg::t_lane f_step(scd_pkg::t_lane a, logic [RW-1:0] d);
        logic [RW:0]    trial;
        logic           take;
        scd_pkg::t_lane b;
        trial  = {a.rem, a.bits[QW-1]};
        take   = trial >= {1'b0, d};
        b      = a;
        b.rem  = take ? RW'(trial - {1'b0, d}) : trial[RW-1:0];
        b.bits = {a.bits[QW-2:0], take};
        return b;
    endfunction

    always_comb begin
        n_data        = i_data;
        n_data.lane_l = f_step(i_data.lane_l, i_divisor);
        n_data.lane_r = f_step(i_data.lane_r, i_divisor);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

>>> sv/signed_command_to_dual_pwm.sv
// Maps a signed drive command to a direction and PWM compare value for two motors.
// Pipeline: 23 register stages; a result is held in the output register until it transfers.
// Throughput: one command per cycle unless o_res.ready stalls the pipeline; the divider is
// a row of 17 cells, one quotient bit per cell and cycle, behind five clamp and multiply
// stages.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module signed_command_to_dual_pwm #(
    parameter int COMPARE_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scd_cmd_if.sink    i_cmd,
    scd_cfg_if.sink    i_cfg,
    scd_res_if.source  o_res
);

    localparam int NC = scd_pkg::DIV_CELLS;
    localparam int QW = scd_pkg::Q_W;
    localparam int WW = ((COMPARE_WIDTH > QW) ? COMPARE_WIDTH : QW) + 1;

    scd_pkg::t_cfg      cfg;
    logic [NC:0]        c_valid;
    logic [NC:0]        c_ready;
    scd_pkg::t_div_data c_data [NC+1];

    logic                     out_rdy;
    logic                     r_out_valid;
    logic [1:0]               r_dir;
    logic [COMPARE_WIDTH-1:0] r_left_duty, r_right_duty;
    logic [COMPARE_WIDTH-1:0] n_left_duty, n_right_duty;

    function automatic logic [COMPARE_WIDTH-1:0] f_duty(scd_pkg::t_lane a, logic zero);
        logic [WW-1:0] lim_w;
        logic [WW-1:0] res_w;
        lim_w = (WW'(1) << COMPARE_WIDTH) - WW'(1);
        res_w = WW'(a.sat ? a.sat_val : a.bits);
        if (zero) begin
            return '0;
        end else if (res_w > lim_w) begin
            return lim_w[COMPARE_WIDTH-1:0];
        end else begin
            return res_w[COMPARE_WIDTH-1:0];
        end
    endfunction

    scd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    scd_premap u_premap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (i_cmd),
        .o_valid (c_valid[0]),
        .o_data  (c_data[0]),
        .i_ready (c_ready[0])
    );

    for (genvar g = 0; g < NC; g++) begin : g_cell
        scd_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (cfg.cmd_ceiling),
            .i_valid   (c_valid[g]),
            .i_data    (c_data[g]),
            .o_ready   (c_ready[g]),
            .o_valid   (c_valid[g+1]),
            .o_data    (c_data[g+1]),
            .i_ready   (c_ready[g+1])
        );
    end

    assign out_rdy     = !r_out_valid || o_res.ready;
    assign c_ready[NC] = out_rdy;

    assign n_left_duty  = f_duty(c_data[NC].lane_l, c_data[NC].zero);
    assign n_right_duty = f_duty(c_data[NC].lane_r, c_data[NC].zero);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_rdy) begin
            r_out_valid <= c_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_dir        <= c_data[NC].dir;
            r_left_duty  <= n_left_duty;
            r_right_duty <= n_right_duty;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.left_dir   = r_dir;
    assign o_res.right_dir  = r_dir;
    assign o_res.left_duty  = r_left_duty;
    assign o_res.right_duty = r_right_duty;

endmodule
